// ----- design/tlcse_pkg.sv -----
// ----------------------------------------------------------------------------
// tlcse_pkg
// Sizes, field widths and the per-block coincidence function for the
// two-layer coincidence section encoder.
// ----------------------------------------------------------------------------
package tlcse_pkg;

  // Channels per layer and number of readout sections.
  localparam int LENGTH   = 32;
  localparam int SECTIONS = 8;

  localparam int TOTAL    = 2 * LENGTH;
  localparam int SEC_LEN  = TOTAL / SECTIONS;
  // Only eight sections fit the result fields.
  localparam int OUT_SECS = (SECTIONS < 8) ? SECTIONS : 8;
  // Offsets at or above seven all read as seven, so only the first seven
  // places of a section need a priority scan.
  localparam int SCAN_LEN = (SEC_LEN < 7) ? SEC_LEN : 7;

  // Fixed field widths.
  localparam int PAT_W  = 32;
  localparam int COIN_W = 64;
  localparam int HITS_W = 8;
  localparam int OFS_W  = 3;
  localparam int POS_W  = 24;
  localparam int IN_W   = 2 * PAT_W;
  localparam int USER_W = 2;
  localparam int OUT_W  = COIN_W + HITS_W + POS_W;

  typedef logic [LENGTH-1:0] block_t;

  // Interleave a layer: lower-half channel i at even place 2i, upper-half
  // channel i at odd place 2i+1. With odd LENGTH the last place stays zero.
  function automatic block_t interleave(input logic [PAT_W-1:0] pat);
    block_t b;
    b = '0;
    for (int i = 0; i < LENGTH / 2; i++) begin
      b[2*i]   = pat[i];
      b[2*i+1] = pat[i + LENGTH/2];
    end
    return b;
  endfunction

  // Per-place 1-of-2 coincidence inside one block.
  function automatic block_t coincide(input block_t b, input logic strict);
    logic [LENGTH+3:0] p;   // place j of the block sits at p[j+2]
    block_t c;
    p = {2'b00, b, 2'b00};
    c = '0;
    for (int k = 0; k < LENGTH; k++) begin
      if (strict) begin
        c[k] = (k > 0) && p[k+1] && p[k+2];
      end else if (k == 0) begin
        c[k] = p[2] && !p[3];
      end else if (k == 1) begin
        c[k] = (p[2] && p[3]) || (p[2] && !p[3]) ||
               (p[3] && !p[2] && !p[4]) || (p[2] && p[4] && !p[3]);
      end else if (k == LENGTH - 1) begin
        c[k] = (p[k+1] && p[k+2]) || (p[k+1] && !p[k] && !p[k+2]) ||
               (p[k] && p[k+2] && !p[k+1]) || (p[k+2] && !p[k+1]);
      end else begin
        c[k] = (p[k+1] && p[k+2]) || (p[k+1] && !p[k] && !p[k+2]) ||
               (p[k] && p[k+2] && !p[k+1]) || (p[k+2] && !p[k+1] && !p[k+3]) ||
               (p[k+1] && p[k+3] && !p[k+2]);
      end
    end
    return c;
  endfunction

endpackage

// ----- design/two_layer_coincidence_section_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// two_layer_coincidence_section_encoder_unit
// Two-layer 1-of-2 coincidence with per-section hit flag and lowest offset.
// ----------------------------------------------------------------------------
// A new pattern pair is accepted every clock cycle while the output side does
// not hold the flow. A transaction is first held in the input register, then
// the interleave, coincidence and section encode form a single combinational
// pass into the result register. The input register keeps taking
// transactions while a finished result waits on the master side, so one
// stalled result costs no throughput until the input register is also full.
// A transaction with neither layer present yields no result. Layer 1 fills
// the low block of coincidence_bits and layer 0 the high block. The
// strict_mode register selects the plain neighbor AND and must be written
// only while the block is empty; the configuration channel is always ready.
module two_layer_coincidence_section_encoder_unit (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration: bit 0 is strict_mode.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data,
  // Input: tdata = layer0_pattern[31:0], layer1_pattern[63:32].
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [tlcse_pkg::IN_W-1:0]   s_tdata,
  // Input: tuser = layer0_present[0], layer1_present[1].
  input  logic [tlcse_pkg::USER_W-1:0] s_tuser,
  // Output: tdata = coincidence_bits[63:0], section_hits[71:64],
  // section_positions[95:72].
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [tlcse_pkg::OUT_W-1:0]  m_tdata
);
  import tlcse_pkg::*;

  logic strict;

  // Input register.
  logic             s1_valid;
  logic [PAT_W-1:0] s1_pat0;
  logic [PAT_W-1:0] s1_pat1;
  logic             s1_p0;
  logic             s1_p1;

  // Result register.
  logic              out_valid;
  logic [COIN_W-1:0] out_coin;
  logic [HITS_W-1:0] out_hits;
  logic [POS_W-1:0]  out_pos;

  logic              out_free;
  logic              s_accept;
  logic [COIN_W-1:0] coin_next;
  logic [HITS_W-1:0] hits_next;
  logic [POS_W-1:0]  pos_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = !s1_valid || out_free;
  assign s_accept  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict <= 1'b0;
    end else if (cfg_valid) begin
      strict <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_pat0 <= s_tdata[PAT_W-1:0];
      s1_pat1 <= s_tdata[IN_W-1:PAT_W];
      s1_p0   <= s_tuser[0];
      s1_p1   <= s_tuser[1];
    end
  end

  // Coincidence and section encode. An absent layer reads as all zero.
  always_comb begin
    block_t      blk0;
    block_t      blk1;
    logic [TOTAL-1:0] coin;
    logic        hit;
    logic [OFS_W-1:0] ofs;
    blk0 = s1_p1 ? interleave(s1_pat1) : '0;
    blk1 = s1_p0 ? interleave(s1_pat0) : '0;
    coin = {coincide(blk1, strict), coincide(blk0, strict)};
    coin_next = COIN_W'(coin);
    hits_next = '0;
    pos_next  = '0;
    for (int s = 0; s < OUT_SECS; s++) begin
      hit = 1'b0;
      for (int j = 0; j < SEC_LEN; j++) begin
        hit = hit | coin[s*SEC_LEN + j];
      end
      // Offsets of seven and above saturate; scan only the first seven.
      ofs = hit ? OFS_W'(7) : '0;
      for (int j = SCAN_LEN - 1; j >= 0; j--) begin
        if (coin[s*SEC_LEN + j]) begin
          ofs = OFS_W'(j);
        end
      end
      hits_next[s] = hit;
      pos_next[OFS_W*s +: OFS_W] = ofs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && (s1_p0 || s1_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_coin <= coin_next;
      out_hits <= hits_next;
      out_pos  <= pos_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_pos, out_hits, out_coin};

  // An item with no layer present must not produce a result.
  a_no_layer_no_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free && !s1_p0 && !s1_p1) |=> !m_tvalid)
    else $error("result produced for an item with no layer present");

  // A blocked input register holds its item.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_pat0) && $stable(s1_pat1)))
    else $error("input register changed while blocked");

  // Without layer 1 the low block carries no coincidence in either mode.
  a_absent_block_empty: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free && !s1_p1) |=> (out_coin[LENGTH-1:0] == '0))
    else $error("coincidence in low block without layer 1");

  // A result with no section hit reports every offset as zero.
  a_pos_zero_without_hits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_hits == '0) |-> (out_pos == '0))
    else $error("nonzero offset with no section hits");

endmodule

// ----- tb/sv/coincidence_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coincidence_checker
// Watches the configuration, input and result channels of the two-layer
// coincidence section encoder, predicts every result and compares it.
// ----------------------------------------------------------------------------
module coincidence_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_data,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  // tdata = layer0_pattern, layer1_pattern (lowest bit up).
  input  logic [tlcse_pkg::IN_W-1:0]   s_tdata,
  // tuser = layer0_present, layer1_present (lowest bit up).
  input  logic [tlcse_pkg::USER_W-1:0] s_tuser,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  // tdata = coincidence_bits, section_hits, section_positions (lowest bit up).
  input  logic [tlcse_pkg::OUT_W-1:0]  m_tdata,
  output int                           error_count,
  output int                           pending
);

  import tlcse_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [HITS_W-1:0] hits;
    logic [COIN_W-1:0] coin;
  } section_word_t;

  typedef logic [LENGTH-1:0] places_t;

  section_word_t predicted_sections[$];
  section_word_t want;
  section_word_t got;
  logic          strict_q;
  int            errs;

  // Place q of a block: even places carry the lower half of the layer,
  // odd places the upper half.
  function automatic places_t spread_layer(input logic [PAT_W-1:0] pat);
    places_t b;
    b = '0;
    for (int q = 0; q < LENGTH; q++) begin
      if (q / 2 < LENGTH / 2) begin
        b[q] = (q % 2 == 0) ? pat[q / 2] : pat[q / 2 + LENGTH / 2];
      end
    end
    return b;
  endfunction

  function automatic logic place_at(input places_t b, input int i);
    return (i >= 0 && i < LENGTH) ? b[i] : 1'b0;
  endfunction

  function automatic places_t pair_coincidence(input places_t b, input logic strict);
    places_t c;
    logic    a, m, h, n;
    c = '0;
    for (int k = 0; k < LENGTH; k++) begin
      a = place_at(b, k - 2);
      m = place_at(b, k - 1);
      h = place_at(b, k);
      n = place_at(b, k + 1);
      if (strict) begin
        c[k] = (k > 0) && m && h;
      end else if (k == 0) begin
        c[k] = h && !n;
      end else if (k == 1) begin
        c[k] = (m && h) || (m && !h) || (h && !m && !n) || (m && n && !h);
      end else if (k == LENGTH - 1) begin
        c[k] = (m && h) || (m && !a && !h) || (a && h && !m) || (h && !m);
      end else begin
        c[k] = (m && h) || (m && !a && !h) || (a && h && !m) ||
               (h && !m && !n) || (m && n && !h);
      end
    end
    return c;
  endfunction

  function automatic section_word_t predict_sections(input logic [PAT_W-1:0] l0,
                                                     input logic [PAT_W-1:0] l1,
                                                     input logic p0, input logic p1,
                                                     input logic strict);
    section_word_t w;
    places_t       lo, hi;
    int            seclen, place, nsec;
    logic          found;
    w      = '0;
    lo     = pair_coincidence(spread_layer(p1 ? l1 : '0), strict);
    hi     = pair_coincidence(spread_layer(p0 ? l0 : '0), strict);
    seclen = TOTAL / SECTIONS;
    nsec   = (SECTIONS < 8) ? SECTIONS : 8;
    for (int k = 0; k < LENGTH; k++) begin
      w.coin[k]          = lo[k];
      w.coin[LENGTH + k] = hi[k];
    end
    for (int s = 0; s < nsec; s++) begin
      found = 1'b0;
      for (int j = 0; j < seclen; j++) begin
        place = s * seclen + j;
        if (!found && place < TOTAL && w.coin[place]) begin
          found          = 1'b1;
          w.hits[s]      = 1'b1;
          w.pos[3*s +: 3] = (j > 7) ? 3'd7 : j[2:0];
        end
      end
    end
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      strict_q = 1'b0;
      errs     = 0;
      predicted_sections.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        strict_q = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (predicted_sections.size() == 0) begin
          $display("%0t: result with no transaction pending: got %h", $time, got);
          errs++;
        end else begin
          want = predicted_sections.pop_front();
          if (got.coin !== want.coin) begin
            $display("%0t: coincidence_bits mismatch: expected %h, got %h",
                     $time, want.coin, got.coin);
            errs++;
          end
          if (got.hits !== want.hits) begin
            $display("%0t: section_hits mismatch: expected %h, got %h",
                     $time, want.hits, got.hits);
            errs++;
          end
          if (got.pos !== want.pos) begin
            $display("%0t: section_positions mismatch: expected %h, got %h",
                     $time, want.pos, got.pos);
            errs++;
          end
        end
      end
      // A transaction with neither layer present produces nothing.
      if (s_tvalid && s_tready && s_tuser != '0) begin
        predicted_sections.push_back(predict_sections(s_tdata[PAT_W-1:0],
                                                      s_tdata[IN_W-1:PAT_W],
                                                      s_tuser[0], s_tuser[1],
                                                      strict_q));
      end
    end
    pending     <= predicted_sections.size();
    error_count <= errs;
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-layer coincidence section encoder.
// Directed pattern pairs in both coincidence modes are followed by random
// phases with varied idling on both channels; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  import tlcse_pkg::*;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data  = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  // tdata = layer0_pattern, layer1_pattern (lowest bit up).
  logic [IN_W-1:0]     s_tdata   = '0;
  // tuser = layer0_present, layer1_present (lowest bit up).
  logic [USER_W-1:0]   s_tuser   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  // tdata = coincidence_bits, section_hits, section_positions (lowest bit up).
  logic [OUT_W-1:0]    m_tdata;

  int errors;
  int pending;

  // Idle percentages for the sender and the receiver; each phase sets them.
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_layer_coincidence_section_encoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  coincidence_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .error_count (errors),
    .pending     (pending)
  );

  // Length of an idle stretch, drawn with a chance of pct percent: mostly
  // short, now and then a long one so that the input register and the result
  // register both fill up behind a stalled receiver.
  function automatic int idle_len(input int pct);
    int r;
    if ($urandom_range(99) >= pct) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 93) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // A mix of dense, sparse and clustered hit patterns. Sparse patterns
  // spread the lowest set offsets over all places of a section, and pairs
  // of channels that land on neighboring places exercise the AND terms.
  function automatic logic [PAT_W-1:0] random_pattern();
    logic [PAT_W-1:0] p;
    int               c;
    p = '0;
    case ($urandom_range(0, 5))
      0: begin
        p = $urandom;
      end
      1: begin
        repeat ($urandom_range(1, 4)) p[$urandom_range(0, PAT_W - 1)] = 1'b1;
      end
      2: begin
        p = '1;
        repeat ($urandom_range(1, 4)) p[$urandom_range(0, PAT_W - 1)] = 1'b0;
      end
      3: begin
        // Channels c and c+16 sit on neighboring places 2c and 2c+1.
        repeat ($urandom_range(1, 3)) begin
          c = $urandom_range(0, PAT_W / 2 - 1);
          p[c] = 1'b1;
          p[c + PAT_W / 2] = 1'b1;
        end
      end
      4: begin
        p = $urandom & $urandom & $urandom;
      end
      default: begin
        p = $urandom_range(0, 1) ? '1 : '0;
      end
    endcase
    return p;
  endfunction

  // The receiver side. It stalls for random stretches, the length of the
  // stall counted in cycles, with the pressure set by out_idle_pct.
  initial begin : result_drain
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        hold = idle_len(out_idle_pct);
        m_tready <= (hold == 0);
        if (hold > 0) begin
          hold--;
        end
      end
    end
  end

  // Offer one pattern pair and hold it until the block accepts it. An idle
  // stretch, if one is drawn, comes before the transaction, so valid is
  // never lowered and raised again in one time step.
  task automatic send_pair(input logic [PAT_W-1:0] l0, input logic [PAT_W-1:0] l1,
                           input logic p0, input logic p1);
    int n;
    n = idle_len(in_idle_pct);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {l1, l0};
    s_tuser  <= {p1, p0};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drain the block: wait until every predicted result has arrived, then wait on
  // so that a transaction without result still in flight has passed through.
  task automatic drain_block();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // strict_mode may only change while the block is empty.
  task automatic write_strict(input logic v);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Extremes of the patterns, every presence combination, the edge places
  // of both blocks, and the gap and neighbor cases of the coincidence.
  task automatic directed_pairs();
    send_pair(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // Neither layer present: nothing may come out.
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1);
    send_pair(32'h0000_FFFF, 32'hFFFF_0000, 1'b1, 1'b0);
    send_pair(32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 1'b1);
    // First two places of each block, and the last two.
    send_pair(32'h0001_0001, 32'h8000_8000, 1'b1, 1'b1);
    send_pair(32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1);
    send_pair(32'h8000_0000, 32'h0000_8000, 1'b1, 1'b1);
    send_pair(32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b1);
    send_pair(32'h0003_0003, 32'hC000_C000, 1'b1, 1'b0);
    // Places 0 and 2 set with place 1 clear in the layer 0 block.
    send_pair(32'h0000_0003, 32'h0001_0002, 1'b1, 1'b1);
    send_pair(32'hDEAD_BEEF, 32'h0000_0000, 1'b0, 1'b0);
  endtask

  initial begin : stimulus
    int          r;
    logic        p0, p1;
    int          in_pct[5];
    int          out_pct[5];

    in_pct  = '{0, 30, 60, 15, 5};
    out_pct = '{0, 30, 15, 60, 5};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, once in each coincidence mode, with light idling.
    in_idle_pct  = 20;
    out_idle_pct = 20;
    write_strict(1'b0);
    directed_pairs();
    write_strict(1'b1);
    directed_pairs();

    // Random phases alternate the mode and the pressure on each side; the
    // first phase runs with no idling at all.
    for (int ph = 0; ph < 5; ph++) begin
      write_strict(ph[0]);
      in_idle_pct  = in_pct[ph];
      out_idle_pct = out_pct[ph];
      for (int i = 0; i < 110; i++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          p0 = 1'b0;
          p1 = 1'b0;
        end else if (r < 30) begin
          p0 = 1'b1;
          p1 = 1'b0;
        end else if (r < 52) begin
          p0 = 1'b0;
          p1 = 1'b1;
        end else begin
          p0 = 1'b1;
          p1 = 1'b1;
        end
        send_pair(random_pattern(), random_pattern(), p0, p1);
      end
    end

    // Let every result arrive, then wait on for anything stray.
    drain_block();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run with every stall drawn long.
  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
